FILE: rtl/core/ehash_pkg.sv
package ehash_pkg;

  localparam int BSIZE_W     = 3;
  localparam int NB_W        = 9;
  localparam int BSIZE_RESET = 4;
  localparam int PADDR_W     = 3;

  localparam logic FUNC_FIND = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  localparam logic REG_BUCKET_SIZE = 1'b0;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_MISSING = 3'd1,
    ST_ADDED   = 3'd2,
    ST_DUP     = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_DIR_RD,
    S_DIR_WAIT,
    S_META_WAIT,
    S_KEY_RD,
    S_KEY_CMP,
    S_DECIDE,
    S_SPLIT,
    S_DBL_RD,
    S_DBL_W0,
    S_DBL_W1,
    S_FILL_INIT,
    S_FILL,
    S_RD_DIR,
    S_RD_T,
    S_META_NB,
    S_META_B,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        func;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  bucket_index;
    logic [3:0]  global_depth;
  } rsp_t;

endpackage

FILE: rtl/core/ehash_ram.sv
module ehash_ram
  import ehash_pkg::*;
#(
  parameter int W  = 8,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [1<<AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/ehash_ctrl.sv
module ehash_ctrl
  import ehash_pkg::*;
#(
  parameter int MAX_DEPTH  = 8,
  parameter int BUCKET_CAP = 4,
  parameter int KEY_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BSIZE_W-1:0]   slot_limit,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output rsp_t                 rsp,
  output logic                 dir_we,
  output logic [MAX_DEPTH-1:0] dir_waddr,
  output logic [MAX_DEPTH-1:0] dir_wdata,
  output logic [MAX_DEPTH-1:0] dir_raddr,
  input  logic [MAX_DEPTH-1:0] dir_rdata,
  output logic                 meta_we,
  output logic [MAX_DEPTH-1:0] meta_waddr,
  output logic [$clog2(MAX_DEPTH+1)+$clog2(BUCKET_CAP+1)-1:0] meta_wdata,
  output logic [MAX_DEPTH-1:0] meta_raddr,
  input  logic [$clog2(MAX_DEPTH+1)+$clog2(BUCKET_CAP+1)-1:0] meta_rdata,
  output logic                 key_we,
  output logic [MAX_DEPTH+((BUCKET_CAP>1)?$clog2(BUCKET_CAP):1)-1:0] key_waddr,
  output logic [((KEY_BITS<32)?KEY_BITS:32)-1:0] key_wdata,
  output logic [MAX_DEPTH+((BUCKET_CAP>1)?$clog2(BUCKET_CAP):1)-1:0] key_raddr,
  input  logic [((KEY_BITS<32)?KEY_BITS:32)-1:0] key_rdata
);

  localparam int AW = MAX_DEPTH;
  localparam int SW = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
  localparam int CW = $clog2(BUCKET_CAP + 1);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

  function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] k, input logic [LW-1:0] d);
    logic [AW+KW-1:0] kx;
    logic [AW-1:0]    r;
    kx = {{AW{1'b0}}, k};
    for (int i = 0; i < AW; i++) begin
      r[AW-1-i] = kx[i];
    end
    return r >> (AW - int'(d));
  endfunction

  state_t state, state_next;

  logic          func;
  logic [KW-1:0] key;
  logic [AW-1:0] b, nb, dv, dbl_i, fa, fend;
  logic [CW-1:0] n, j, cnt_b, cnt_nb;
  logic [LW-1:0] ld, depth;
  logic          hit;
  status_t       st;
  logic [NB_W-1:0] next_bucket;
  logic [KW-1:0] held [1<<SW];

  logic [CW-1:0] cap_sz;
  logic [CW-1:0] meta_cnt;
  logic [LW-1:0] meta_ld;
  logic [CW-1:0] sel_cnt;
  logic [AW-1:0] shared;
  logic [AW-1:0] fill_start, fill_end;
  int            fill;

  assign meta_cnt = meta_rdata[CW-1:0];
  assign meta_ld  = meta_rdata[LW+CW-1:CW];
  assign sel_cnt  = (dir_rdata == b) ? cnt_b : cnt_nb;

  always_comb begin
    if (slot_limit == '0) begin
      cap_sz = CW'(1);
    end else if (int'(slot_limit) > BUCKET_CAP) begin
      cap_sz = CW'(BUCKET_CAP);
    end else begin
      cap_sz = CW'(slot_limit);
    end
  end

  always_comb begin
    shared     = addr_of(key, ld);
    fill       = int'(depth) - int'(ld) - 1;
    fill_start = AW'(((int'(shared) << 1) | 1) << fill);
    fill_end   = fill_start | AW'((1 << fill) - 1);
  end

  assign req_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:      state_next = S_IDLE;
      S_IDLE:      if (req_valid) state_next = S_DIR_RD;
      S_DIR_RD:    state_next = S_DIR_WAIT;
      S_DIR_WAIT:  state_next = S_META_WAIT;
      S_META_WAIT: state_next = (meta_cnt != '0) ? S_KEY_RD : S_DECIDE;
      S_KEY_RD:    state_next = S_KEY_CMP;
      S_KEY_CMP:   state_next = (j + CW'(1) < n) ? S_KEY_RD : S_DECIDE;
      S_DECIDE: begin
        if (func == FUNC_FIND || hit || n < cap_sz || ld >= LW'(MAX_DEPTH)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT:     state_next = (ld >= depth) ? S_DBL_RD : S_FILL_INIT;
      S_DBL_RD:    state_next = S_DBL_W0;
      S_DBL_W0:    state_next = S_DBL_W1;
      S_DBL_W1:    state_next = (dbl_i == '0) ? S_FILL_INIT : S_DBL_RD;
      S_FILL_INIT: state_next = S_FILL;
      S_FILL: begin
        if (fa == fend) state_next = (n == '0) ? S_META_NB : S_RD_DIR;
      end
      S_RD_DIR:    state_next = S_RD_T;
      S_RD_T:      state_next = (j + CW'(1) < n) ? S_RD_DIR : S_META_NB;
      S_META_NB:   state_next = S_META_B;
      S_META_B:    state_next = S_DIR_RD;
      S_DONE:      if (!rsp_valid || rsp_ready) state_next = S_IDLE;
      default:     state_next = S_INIT;
    endcase
  end

  // memory controls
  always_comb begin
    dir_we     = 1'b0;
    dir_waddr  = '0;
    dir_wdata  = '0;
    dir_raddr  = '0;
    meta_we    = 1'b0;
    meta_waddr = '0;
    meta_wdata = '0;
    meta_raddr = dir_rdata;
    key_we     = 1'b0;
    key_waddr  = '0;
    key_wdata  = key;
    key_raddr  = {b, SW'(j)};
    unique case (state)
      S_INIT: begin
        dir_we  = 1'b1;
        meta_we = 1'b1;
      end
      S_DIR_RD: dir_raddr = addr_of(key, depth);
      S_DECIDE: begin
        if (func == FUNC_ADD && !hit && n < cap_sz) begin
          key_we     = 1'b1;
          key_waddr  = {b, SW'(n)};
          meta_we    = 1'b1;
          meta_waddr = b;
          meta_wdata = {ld, n + CW'(1)};
        end
      end
      S_DBL_RD: dir_raddr = dbl_i;
      S_DBL_W0: begin
        dir_we    = 1'b1;
        dir_waddr = AW'({dbl_i, 1'b0});
        dir_wdata = dir_rdata;
      end
      S_DBL_W1: begin
        dir_we    = 1'b1;
        dir_waddr = AW'({dbl_i, 1'b1});
        dir_wdata = dv;
      end
      S_FILL: begin
        dir_we    = 1'b1;
        dir_waddr = fa;
        dir_wdata = nb;
      end
      S_RD_DIR: dir_raddr = addr_of(held[SW'(j)], depth);
      S_RD_T: begin
        key_we    = (sel_cnt < CW'(BUCKET_CAP));
        key_waddr = {dir_rdata, SW'(sel_cnt)};
        key_wdata = held[SW'(j)];
      end
      S_META_NB: begin
        meta_we    = 1'b1;
        meta_waddr = nb;
        meta_wdata = {ld + LW'(1), cnt_nb};
      end
      S_META_B: begin
        meta_we    = 1'b1;
        meta_waddr = b;
        meta_wdata = {ld + LW'(1), cnt_b};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      depth       <= '0;
      next_bucket <= NB_W'(1);
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_valid && rsp_ready && state != S_DONE) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            func <= req.func;
            key  <= KW'(req.key);
          end
        end
        S_DIR_WAIT: b <= dir_rdata;
        S_META_WAIT: begin
          n   <= meta_cnt;
          ld  <= meta_ld;
          j   <= '0;
          hit <= 1'b0;
        end
        S_KEY_CMP: begin
          if (key_rdata == key) hit <= 1'b1;
          held[SW'(j)] <= key_rdata;
          j <= j + CW'(1);
        end
        S_DECIDE: begin
          if (func == FUNC_FIND) begin
            st <= hit ? ST_FOUND : ST_MISSING;
          end else if (hit) begin
            st <= ST_DUP;
          end else if (n < cap_sz) begin
            st <= ST_ADDED;
          end else begin
            st <= ST_FULL;
          end
        end
        S_SPLIT: begin
          nb          <= AW'(next_bucket);
          next_bucket <= next_bucket + NB_W'(1);
          dbl_i       <= AW'((1 << int'(depth)) - 1);
        end
        S_DBL_W0: dv <= dir_rdata;
        S_DBL_W1: begin
          if (dbl_i == '0) begin
            depth <= depth + LW'(1);
          end else begin
            dbl_i <= dbl_i - AW'(1);
          end
        end
        S_FILL_INIT: begin
          fa   <= fill_start;
          fend <= fill_end;
        end
        S_FILL: begin
          fa     <= fa + AW'(1);
          j      <= '0;
          cnt_b  <= '0;
          cnt_nb <= '0;
        end
        S_RD_T: begin
          if (sel_cnt < CW'(BUCKET_CAP)) begin
            if (dir_rdata == b)  cnt_b  <= cnt_b + CW'(1);
            if (dir_rdata == nb) cnt_nb <= cnt_nb + CW'(1);
          end
          j <= j + CW'(1);
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= st;
            rsp.bucket_index <= 8'(b);
            rsp.global_depth <= 4'(depth);
          end
        end
        default: ;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= LW'(MAX_DEPTH))
    else $error("directory depth above limit");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    key_we |-> int'(key_waddr[SW-1:0]) < BUCKET_CAP)
    else $error("key written past bucket capacity");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside done state");

  a_split_below_max: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT |-> ld < LW'(MAX_DEPTH))
    else $error("split at maximum local depth");

endmodule

FILE: rtl/core/extendible_hash_table.sv
// channel | dir | handshake             | word
// req     | in  | req_valid/req_ready   | req_t: func, key
// rsp     | out | rsp_valid/rsp_ready   | rsp_t: status, bucket_index, global_depth
// cfg     | in  | psel/penable/pready   | slot_limit at byte 0
//
// Find/add: directory read, metadata read, then each key in the bucket is read and compared.
// Each split doubles the directory when the local depth has reached the global depth, then
// fills the new bucket's directory entries and moves the held keys; the lookup then runs again.
// Reset: the init state writes directory entry 0 and bucket 0's metadata.
// One word in flight; a held response stalls only the next result.
module extendible_hash_table
  import ehash_pkg::*;
#(
  parameter int MAX_DEPTH  = 8,
  parameter int BUCKET_CAP = 4,
  parameter int KEY_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = MAX_DEPTH;
  localparam int SW = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
  localparam int CW = $clog2(BUCKET_CAP + 1);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;

  logic [BSIZE_W-1:0] slot_limit;

  logic          dir_we;
  logic [AW-1:0] dir_waddr, dir_wdata, dir_raddr, dir_rdata;
  logic          meta_we;
  logic [AW-1:0] meta_waddr, meta_raddr;
  logic [LW+CW-1:0] meta_wdata, meta_rdata;
  logic          key_we;
  logic [AW+SW-1:0] key_waddr, key_raddr;
  logic [KW-1:0] key_wdata, key_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_limit <= BSIZE_W'(BSIZE_RESET);
    end else if (psel && penable && pwrite && paddr[2] == REG_BUCKET_SIZE) begin
      slot_limit <= pwdata[BSIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUCKET_SIZE) ? 32'(slot_limit) : 32'd0;

  ehash_ram #(.W(AW), .AW(AW)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  ehash_ram #(.W(LW+CW), .AW(AW)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  ehash_ram #(.W(KW), .AW(AW+SW)) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  ehash_ctrl #(
    .MAX_DEPTH  (MAX_DEPTH),
    .BUCKET_CAP (BUCKET_CAP),
    .KEY_BITS   (KEY_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .slot_limit  (slot_limit),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .dir_we      (dir_we),
    .dir_waddr   (dir_waddr),
    .dir_wdata   (dir_wdata),
    .dir_raddr   (dir_raddr),
    .dir_rdata   (dir_rdata),
    .meta_we     (meta_we),
    .meta_waddr  (meta_waddr),
    .meta_wdata  (meta_wdata),
    .meta_raddr  (meta_raddr),
    .meta_rdata  (meta_rdata),
    .key_we      (key_we),
    .key_waddr   (key_waddr),
    .key_wdata   (key_wdata),
    .key_raddr   (key_raddr),
    .key_rdata   (key_rdata)
  );

endmodule

FILE: tb/testbench.sv
module testbench;
  import ehash_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXD = 8;
  localparam int CAP = 4;
  localparam int DIRN = 256;
  localparam int WDOG_LIMIT = 40000;

  logic clk, rst;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  req_t req;
  rsp_t rsp;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  extendible_hash_table uut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // shadow table
  logic [7:0]  dir_tbl [DIRN];
  logic [31:0] slot_key [DIRN*CAP];
  int unsigned slot_cnt [DIRN];
  int unsigned loc_depth [DIRN];
  int unsigned gdepth;
  int unsigned nxt_bkt;
  logic [2:0]  bsize;

  rsp_t rsp_q[$];
  int errors;
  int idle_pct;
  int wdog;
  logic [31:0] keys_added[$];

  function automatic int unsigned dir_addr(logic [31:0] k, int unsigned d);
    int unsigned a;
    a = 0;
    for (int i = 0; i < d; i++) a = (a << 1) | k[i];
    return a & (DIRN - 1);
  endfunction

  task automatic split_bucket(int unsigned b, logic [31:0] k);
    int unsigned ld, nb, shared, fill, start, stop, n, t;
    logic [31:0] held[CAP];
    ld = loc_depth[b];
    if (ld >= gdepth) begin
      for (int i = (1 << gdepth) - 1; i >= 0; i--) begin
        dir_tbl[(2*i) & (DIRN-1)] = dir_tbl[i];
        dir_tbl[(2*i+1) & (DIRN-1)] = dir_tbl[i];
      end
      gdepth++;
    end
    nb = nxt_bkt & (DIRN - 1);
    nxt_bkt = (nxt_bkt + 1) & 9'h1FF;
    shared = dir_addr(k, ld);
    fill = gdepth - ld - 1;
    start = ((shared << 1) | 1) << fill;
    stop = start | ((1 << fill) - 1);
    for (int unsigned i = start; i <= stop && i < DIRN; i++) dir_tbl[i] = nb[7:0];
    loc_depth[b] = ld + 1;
    loc_depth[nb] = ld + 1;
    n = (slot_cnt[b] > CAP) ? CAP : slot_cnt[b];
    for (int i = 0; i < n; i++) held[i] = slot_key[b*CAP+i];
    slot_cnt[b] = 0;
    slot_cnt[nb] = 0;
    for (int i = 0; i < n; i++) begin
      t = dir_tbl[dir_addr(held[i], gdepth)];
      if (slot_cnt[t] < CAP) begin
        slot_key[t*CAP+slot_cnt[t]] = held[i];
        slot_cnt[t]++;
      end
    end
  endtask

  task automatic predict_lookup(req_t r);
    int unsigned b, n, lim;
    bit hit;
    status_t st;
    rsp_t e;
    st = ST_FULL;
    b = 0;
    lim = (bsize == 0) ? 1 : (bsize > CAP) ? CAP : bsize;
    for (int it = 0; it <= MAXD + 1; it++) begin
      b = dir_tbl[dir_addr(r.key, gdepth)];
      n = (slot_cnt[b] > CAP) ? CAP : slot_cnt[b];
      hit = 0;
      for (int i = 0; i < n; i++) if (slot_key[b*CAP+i] == r.key) hit = 1;
      if (r.func == FUNC_FIND) begin
        st = hit ? ST_FOUND : ST_MISSING;
        break;
      end
      if (hit) begin
        st = ST_DUP;
        break;
      end
      if (n < lim) begin
        slot_key[b*CAP+n] = r.key;
        slot_cnt[b] = n + 1;
        st = ST_ADDED;
        break;
      end
      if (loc_depth[b] >= MAXD) begin
        st = ST_FULL;
        break;
      end
      split_bucket(b, r.key);
    end
    e.status = st;
    e.bucket_index = b[7:0];
    e.global_depth = gdepth[3:0];
    rsp_q.push_back(e);
  endtask

  task automatic send_word(logic f, logic [31:0] k);
    req_t r;
    r.func = f;
    r.key = k;
    @(negedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_lookup(r);
    if (f == FUNC_ADD) keys_added.push_back(k);
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  task automatic drain();
    while (rsp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_bsize(logic [2:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(REG_BUCKET_SIZE) << 2;
    pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bsize = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // response check
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (rsp_q.size() == 0) begin
        $display("%0t: unexpected word %p", $time, rsp);
        errors++;
      end else begin
        e = rsp_q.pop_front();
        if (rsp.status !== e.status)
          $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
        if (rsp.bucket_index !== e.bucket_index)
          $display("%0t: bucket exp %0d got %0d", $time, e.bucket_index, rsp.bucket_index);
        if (rsp.global_depth !== e.global_depth)
          $display("%0t: depth exp %0d got %0d", $time, e.global_depth, rsp.global_depth);
        if (rsp !== e) errors++;
      end
    end
  end

  always @(negedge clk) begin
    rsp_ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(FUNC_FIND, 32'h0);
    send_word(FUNC_ADD, 32'h0);
    send_word(FUNC_ADD, 32'h0);
    send_word(FUNC_FIND, 32'h0);
    send_word(FUNC_ADD, 32'hFFFF_FFFF);
    send_word(FUNC_FIND, 32'hFFFF_FFFF);
    send_word(FUNC_FIND, 32'h1234_5678);
    for (int i = 1; i <= 6; i++) send_word(FUNC_ADD, 32'(i));
    send_word(FUNC_ADD, 32'hA5A5_5A5A);
    drain();
  endtask

  // keys sharing low bits push the table toward max depth
  task automatic test_table_full();
    write_bsize(3'd1);
    for (int i = 0; i < 6; i++) send_word(FUNC_ADD, 32'(i) << 12);
    send_word(FUNC_FIND, 32'h0000_1000);
    drain();
  endtask

  task automatic test_random(int n, logic [7:0] lowmask);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if (keys_added.size() != 0 && $urandom_range(3) == 0)
        k = keys_added[$urandom_range(keys_added.size() - 1)];
      else if ($urandom_range(4) == 0)
        k = $urandom;
      else
        k = ($urandom & 32'hFFFF_FF00) | ($urandom & 32'(lowmask));
      send_word($urandom_range(99) < 65 ? FUNC_ADD : FUNC_FIND, k);
    end
    drain();
  endtask

  initial begin
    errors = 0;
    idle_pct = 7;
    wdog = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    for (int i = 0; i < DIRN; i++) begin
      dir_tbl[i] = '0; slot_cnt[i] = 0; loc_depth[i] = 0;
    end
    gdepth = 0;
    nxt_bkt = 1;
    bsize = 3'(BSIZE_RESET);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_table_full();
    write_bsize(3'd0);
    test_random(60, 8'h0F);
    write_bsize(3'd7);
    test_random(120, 8'hFF);
    idle_pct = 0;
    write_bsize(3'd2);
    test_random(100, 8'h3F);
    idle_pct = 7;
    write_bsize(3'd3);
    test_random(150, 8'hFF);
    drain();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/ehash_pkg.sv
rtl/core/ehash_ram.sv
rtl/core/ehash_ctrl.sv
rtl/core/extendible_hash_table.sv
tb/testbench.sv
